>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/sepwm_pkg.sv
// ----------------------------------------------------------------------------
// sepwm_pkg
// Types and constants of the single-edge PWM timer.
// ----------------------------------------------------------------------------
package sepwm_pkg;

  localparam int NUM_OUTPUTS     = 6;
  localparam int COUNT_WIDTH     = 32;
  localparam int NUM_MATCH       = 7;
  localparam int DATA_WIDTH      = 32;
  localparam int PIN_WIDTH       = 6;
  localparam int MATCH_CTL_WIDTH = 3 * NUM_MATCH;
  localparam int OUTEN_SHIFT     = 9;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    REG_CTRL     = 4'd0,
    REG_PRESCALE = 4'd1,
    REG_MATCHCTL = 4'd2,
    REG_OUTEN    = 4'd3,
    REG_LATCH    = 4'd4,
    REG_MATCH0   = 4'd5,
    REG_MATCH1   = 4'd6,
    REG_MATCH2   = 4'd7,
    REG_MATCH3   = 4'd8,
    REG_MATCH4   = 4'd9,
    REG_MATCH5   = 4'd10,
    REG_MATCH6   = 4'd11,
    REG_COUNT    = 4'd12,
    REG_IRQ      = 4'd13
  } reg_t;

  typedef struct packed {
    logic pwm;
    logic rst;
    logic en;
  } tctl_t;

  typedef logic [NUM_MATCH-1:0][DATA_WIDTH-1:0] match_arr_t;

  typedef struct packed {
    logic [NUM_MATCH-1:0] irq_set;
    logic                 do_reset;
    logic                 do_stop;
  } hit_t;

endpackage

>>> hdl/sepwm_req_if.sv
// ----------------------------------------------------------------------------
// sepwm_req_if
// Request channel: tick, register write or register read.
// ----------------------------------------------------------------------------
interface sepwm_req_if
  import sepwm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [3:0]            reg_index;
  logic [DATA_WIDTH-1:0] wdata;

  modport source (output valid, req_type, reg_index, wdata, input ready);
  modport sink   (input valid, req_type, reg_index, wdata, output ready);
endinterface

>>> hdl/sepwm_rsp_if.sv
// ----------------------------------------------------------------------------
// sepwm_rsp_if
// Response channel: read data, pin levels and interrupt line.
// ----------------------------------------------------------------------------
interface sepwm_rsp_if
  import sepwm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] rdata;
  logic [PIN_WIDTH-1:0]  pwm_pins;
  logic                  irq;

  modport source (output valid, rdata, pwm_pins, irq, input ready);
  modport sink   (input valid, rdata, pwm_pins, irq, output ready);
endinterface

>>> hdl/sepwm_cmp.sv
// ----------------------------------------------------------------------------
// sepwm_cmp
// Compares the counter with all active match values and merges the
// per-match controls into interrupt, reset and stop requests.
// ----------------------------------------------------------------------------
module sepwm_cmp
  import sepwm_pkg::*;
(
  input  logic [COUNT_WIDTH-1:0]     count,
  input  match_arr_t                 active,
  input  logic [MATCH_CTL_WIDTH-1:0] match_ctl,
  output hit_t                       hit
);

  logic [NUM_MATCH-1:0] eq;

  always_comb begin
    hit = '0;
    for (int i = 0; i < NUM_MATCH; i++) begin
      eq[i] = (DATA_WIDTH'(count) == active[i]);
      hit.irq_set[i] = eq[i] & match_ctl[3*i];
      if (eq[i] && match_ctl[3*i+1]) begin
        hit.do_reset = 1'b1;
      end
      if (eq[i] && match_ctl[3*i+2]) begin
        hit.do_stop = 1'b1;
      end
    end
  end

endmodule

>>> hdl/single_edge_pwm_timer_top.sv
// A response passes the input register, then the response register; the timer state
// update of a request is made at the same edge that loads its response register.
// Throughput: one request per cycle unless responses stall; response and input
// register form a two-entry buffer, so a request is taken while a response waits.
// Reset: synchronous, active low; clears all timer state, no clearing pass.
// ----------------------------------------------------------------------------
// single_edge_pwm_timer_top
// Six channel single-edge PWM timer with prescaler, seven match registers,
// shadow latching and output enables, driven by a request stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module single_edge_pwm_timer_top
  import sepwm_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  sepwm_req_if.sink   in_req,
  sepwm_rsp_if.source out_rsp
);

  // input register
  logic                  s1_valid_r, s1_valid_nxt;
  logic [1:0]            s1_type_r;
  logic [3:0]            s1_idx_r;
  logic [DATA_WIDTH-1:0] s1_wdata_r;

  // response register
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_rdata_r, out_rdata_nxt;
  logic [PIN_WIDTH-1:0]  out_pins_r, out_pins_nxt;
  logic                  out_irq_r, out_irq_nxt;

  // timer state
  logic [DATA_WIDTH-1:0]      pcount_r, pcount_nxt;
  logic [COUNT_WIDTH-1:0]     count_r, count_nxt;
  logic [DATA_WIDTH-1:0]      plimit_r, plimit_nxt;
  match_arr_t                 active_r, active_nxt;
  match_arr_t                 shadow_r, shadow_nxt;
  logic [NUM_MATCH-1:0]       latch_r, latch_nxt;
  logic [MATCH_CTL_WIDTH-1:0] mctl_r, mctl_nxt;
  logic [NUM_OUTPUTS-1:0]     oen_r, oen_nxt;
  tctl_t                      tctl_r, tctl_nxt;
  logic [NUM_MATCH-1:0]       irqf_r, irqf_nxt;

  logic in_acc;
  logic s1_adv;
  hit_t hit;

  assign s1_adv        = s1_valid_r & (~out_valid_r | out_rsp.ready);
  assign in_req.ready  = ~s1_valid_r | s1_adv;
  assign in_acc        = in_req.valid & in_req.ready;

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.rdata    = out_rdata_r;
  assign out_rsp.pwm_pins = out_pins_r;
  assign out_rsp.irq      = out_irq_r;

  sepwm_cmp u_cmp (
    .count     (count_r),
    .active    (active_r),
    .match_ctl (mctl_r),
    .hit       (hit)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // next state
  always_comb begin
    pcount_nxt = pcount_r;
    count_nxt  = count_r;
    plimit_nxt = plimit_r;
    active_nxt = active_r;
    shadow_nxt = shadow_r;
    latch_nxt  = latch_r;
    mctl_nxt   = mctl_r;
    oen_nxt    = oen_r;
    tctl_nxt   = tctl_r;
    irqf_nxt   = irqf_r;
    if (s1_adv) begin
      case (s1_type_r)
        REQ_TICK: begin
          if (tctl_r.rst) begin
            count_nxt  = '0;
            pcount_nxt = '0;
          end else if (tctl_r.en) begin
            if (pcount_r >= plimit_r) begin
              pcount_nxt = '0;
              irqf_nxt   = irqf_r | hit.irq_set;
              if (hit.do_reset) begin
                count_nxt = '0;
                if (tctl_r.pwm) begin
                  for (int i = 0; i < NUM_MATCH; i++) begin
                    if (latch_r[i]) begin
                      active_nxt[i] = shadow_r[i];
                    end
                  end
                  latch_nxt = '0;
                end
              end else if (hit.do_stop) begin
                tctl_nxt.en = 1'b0;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end else begin
              pcount_nxt = pcount_r + 1'b1;
            end
          end
        end
        REQ_WRITE: begin
          case (s1_idx_r) inside
            REG_CTRL: begin
              tctl_nxt.en  = s1_wdata_r[0];
              tctl_nxt.rst = s1_wdata_r[1];
              tctl_nxt.pwm = s1_wdata_r[3];
              if (s1_wdata_r[1]) begin
                count_nxt  = '0;
                pcount_nxt = '0;
              end
            end
            REG_PRESCALE: plimit_nxt = s1_wdata_r;
            REG_MATCHCTL: mctl_nxt   = s1_wdata_r[MATCH_CTL_WIDTH-1:0];
            REG_OUTEN:    oen_nxt    = s1_wdata_r[OUTEN_SHIFT +: NUM_OUTPUTS];
            REG_LATCH:    latch_nxt  = s1_wdata_r[NUM_MATCH-1:0];
            REG_COUNT:    count_nxt  = s1_wdata_r[COUNT_WIDTH-1:0];
            REG_IRQ:      irqf_nxt   = irqf_r & ~s1_wdata_r[NUM_MATCH-1:0];
            [REG_MATCH0:REG_MATCH6]: begin
              for (int k = 0; k < NUM_MATCH; k++) begin
                if (s1_idx_r == 4'(int'(REG_MATCH0) + k)) begin
                  shadow_nxt[k] = s1_wdata_r;
                  if (!tctl_r.pwm) begin
                    active_nxt[k] = s1_wdata_r;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // response
  always_comb begin
    out_rdata_nxt = '0;
    if (s1_type_r == REQ_READ) begin
      case (s1_idx_r) inside
        REG_CTRL:     out_rdata_nxt = {{(DATA_WIDTH-4){1'b0}}, tctl_r.pwm, 1'b0,
                                       tctl_r.rst, tctl_r.en};
        REG_PRESCALE: out_rdata_nxt = plimit_r;
        REG_MATCHCTL: out_rdata_nxt = DATA_WIDTH'(mctl_r);
        REG_OUTEN:    out_rdata_nxt = DATA_WIDTH'(oen_r) << OUTEN_SHIFT;
        REG_LATCH:    out_rdata_nxt = DATA_WIDTH'(latch_r);
        REG_COUNT:    out_rdata_nxt = DATA_WIDTH'(count_r);
        REG_IRQ:      out_rdata_nxt = DATA_WIDTH'(irqf_r);
        [REG_MATCH0:REG_MATCH6]:
          out_rdata_nxt = shadow_r[3'(s1_idx_r - REG_MATCH0)];
        default:      out_rdata_nxt = '0;
      endcase
    end
    out_pins_nxt = '0;
    for (int ch = 0; ch < NUM_OUTPUTS; ch++) begin
      out_pins_nxt[ch] = tctl_nxt.pwm & oen_nxt[ch] &
                         (DATA_WIDTH'(count_nxt) < active_nxt[ch+1]);
    end
    out_irq_nxt = |irqf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pcount_r    <= '0;
      count_r     <= '0;
      plimit_r    <= '0;
      active_r    <= '0;
      shadow_r    <= '0;
      latch_r     <= '0;
      mctl_r      <= '0;
      oen_r       <= '0;
      tctl_r      <= '0;
      irqf_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pcount_r    <= pcount_nxt;
      count_r     <= count_nxt;
      plimit_r    <= plimit_nxt;
      active_r    <= active_nxt;
      shadow_r    <= shadow_nxt;
      latch_r     <= latch_nxt;
      mctl_r      <= mctl_nxt;
      oen_r       <= oen_nxt;
      tctl_r      <= tctl_nxt;
      irqf_r      <= irqf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_type_r  <= in_req.req_type;
      s1_idx_r   <= in_req.reg_index;
      s1_wdata_r <= in_req.wdata;
    end
    if (s1_adv) begin
      out_rdata_r <= out_rdata_nxt;
      out_pins_r  <= out_pins_nxt;
      out_irq_r   <= out_irq_nxt;
    end
  end

  `ASSERT_CLK(a_irq_tracks_flags, out_valid_r |-> (out_irq_r == (|irqf_r)), "irq vs flags")
  `ASSERT_CLK(a_pins_low_no_pwm, (out_valid_r && !tctl_r.pwm) |-> (out_pins_r == '0), "pins")
  `ASSERT_CLK(a_s1_holds, (s1_valid_r && !s1_adv) |=> s1_valid_r, "buffered request lost")

endmodule
